// ===== src/nims_pkg.sv =====
package nims_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ID_WIDTH_DEF = 16;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_CLEAR  = 3'd2;
    localparam logic [2:0] CMD_LOOKUP = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] node_id;
        logic [3:0]  slot_index;
    } in_t;

    typedef struct packed {
        logic        found;
        logic [15:0] slot_value;
        logic        full_res;
    } out_t;

    // status carried along the cell chain with a command
    typedef struct packed {
        logic valid;
        logic present;
        logic free;
    } flag_t;

endpackage

// ===== src/nims_cell.sv =====
module nims_cell #(
    parameter int ID_WIDTH = 16,
    parameter int IDX_W    = 4,
    parameter int K        = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          cmd,
    input  logic [ID_WIDTH-1:0] id,
    input  logic [3:0]          slot_index,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_idx,
    input  nims_pkg::flag_t     tok_in,
    input  logic [IDX_W-1:0]    free_idx_in,
    input  logic [ID_WIDTH-1:0] value_in,
    output nims_pkg::flag_t     tok_out,
    output logic [IDX_W-1:0]    free_idx_out,
    output logic [ID_WIDTH-1:0] value_out
);
    import nims_pkg::*;

    logic [ID_WIDTH-1:0] slot_reg;
    flag_t               tok_reg;
    flag_t               tok_next;
    logic [IDX_W-1:0]    fidx_reg;
    logic [IDX_W-1:0]    fidx_next;
    logic [ID_WIDTH-1:0] val_reg;
    logic [ID_WIDTH-1:0] val_next;
    logic                match;
    logic                is_free;
    logic                clr;

    assign match   = (slot_reg == id);
    assign is_free = (slot_reg == '0);
    assign clr     = tok_in.valid && ((cmd == CMD_CLEAR) || ((cmd == CMD_DELETE) && match));

    always_comb
    begin
        tok_next.valid   = tok_in.valid;
        tok_next.present = tok_in.present | match;
        tok_next.free    = tok_in.free | is_free;
        fidx_next        = tok_in.free ? free_idx_in : IDX_W'(K);
        val_next         = (int'(slot_index) == K) ? slot_reg : value_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (clr)
            begin
                slot_reg <= '0;
            end
            else if (wr_en && (wr_idx == IDX_W'(K)))
            begin
                slot_reg <= id;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fidx_reg <= fidx_next;
        val_reg  <= val_next;
    end

    assign tok_out      = tok_reg;
    assign free_idx_out = fidx_reg;
    assign value_out    = val_reg;

endmodule

// ===== src/node_id_membership_set.sv =====
// node_id_membership_set: small set of nonzero node identifiers, zero = empty slot.
// Input channel in_valid/in_ready/in_data carries one command per transfer:
// add, delete, clear all, lookup, read slot. Output channel out_valid/out_ready/
// out_data returns exactly one result per command (found, slot_value, full_res).
// Slots sit in a row of CAPACITY cells; a command walks the row one cell per
// cycle, each cell comparing its slot and passing presence, first free slot and
// read data to its neighbor. An add writes its slot in the result load step.
// Steps per command: start step, walk over the row, flag capture, result load,
// then an idle step with in_ready high to take the next; the block takes a new
// command as soon as the previous result is registered, even while that result
// still waits on out_ready.
// Stall: with out_ready low the result holds; a finished command waits in its
// final step until the output register frees, and in_ready stays low meanwhile.
// Reset: all slots empty, no command in flight, out_valid low.
module node_id_membership_set #(
    parameter int CAPACITY = nims_pkg::CAPACITY_DEF,
    parameter int ID_WIDTH = nims_pkg::ID_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  nims_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output nims_pkg::out_t out_data
);
    import nims_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    in_t                 cmd_reg;
    logic                start_reg;
    logic                fin_present_reg;
    logic                fin_free_reg;
    logic [IDX_W-1:0]    fin_idx_reg;
    logic [ID_WIDTH-1:0] fin_value_reg;
    logic                out_valid_reg;
    out_t                out_data_reg;

    flag_t               tok  [0:CAPACITY];
    logic [IDX_W-1:0]    fidx [0:CAPACITY];
    logic [ID_WIDTH-1:0] val  [0:CAPACITY];
    logic [CAPACITY-1:0] tok_valids;

    logic [ID_WIDTH+15:0] id_wide;
    logic [ID_WIDTH-1:0]  id;
    logic [ID_WIDTH+15:0] val_wide;
    logic                 accept;
    logic                 finish;
    logic                 wr_en;
    out_t                 result;

    assign id_wide  = {{ID_WIDTH{1'b0}}, cmd_reg.node_id};
    assign id       = id_wide[ID_WIDTH-1:0];
    assign val_wide = {16'b0, fin_value_reg};

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign finish   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign wr_en    = finish && (cmd_reg.cmd == CMD_ADD) && !fin_present_reg
                      && fin_free_reg && (id != '0);

    always_comb
    begin
        tok[0].valid   = start_reg;
        tok[0].present = 1'b0;
        tok[0].free    = 1'b0;
        fidx[0]        = '0;
        val[0]         = '0;
    end

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        nims_cell #(
            .ID_WIDTH (ID_WIDTH),
            .IDX_W    (IDX_W),
            .K        (k)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd_reg.cmd),
            .id           (id),
            .slot_index   (cmd_reg.slot_index),
            .wr_en        (wr_en),
            .wr_idx       (fin_idx_reg),
            .tok_in       (tok[k]),
            .free_idx_in  (fidx[k]),
            .value_in     (val[k]),
            .tok_out      (tok[k+1]),
            .free_idx_out (fidx[k+1]),
            .value_out    (val[k+1])
        );
        assign tok_valids[k] = tok[k+1].valid;
    end

    always_comb
    begin
        result.found      = (cmd_reg.cmd == CMD_LOOKUP) && fin_present_reg;
        result.slot_value = (cmd_reg.cmd == CMD_READ) ? val_wide[15:0] : 16'b0;
        result.full_res   = (cmd_reg.cmd == CMD_ADD) && !fin_present_reg && !fin_free_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (tok[CAPACITY].valid)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= in_data;
        end
        if (tok[CAPACITY].valid)
        begin
            fin_present_reg <= tok[CAPACITY].present;
            fin_free_reg    <= tok[CAPACITY].free;
            fin_idx_reg     <= fidx[CAPACITY];
            fin_value_reg   <= val[CAPACITY];
        end
        if (finish)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_valids) <= 1)
        else $error("more than one command in the cell row");

    a_wr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (tok_valids == '0) && !start_reg)
        else $error("slot write while a command walks the row");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> start_reg && !in_ready)
        else $error("accepted command did not enter the row");

    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.full_res |-> !out_data.found && (out_data.slot_value == 16'b0))
        else $error("full result with other fields set");

endmodule
